### rtl/core/phrs_pkg.sv
// package for the per-hop round-trip statistics table
// request, result and table entry types, field widths and codes
// no dependencies
package phrs_pkg;

  localparam int unsigned HopCountDefault = 32;
  localparam int unsigned DivSteps        = 24;
  localparam logic [20:0] SmoothMax       = 21'h1FFFFF;
  localparam logic [47:0] VarMax          = 48'hFFFFFFFFFFFF;
  localparam logic [15:0] CountMax        = 16'hFFFF;

  localparam logic       ModeClear    = 1'b1;
  localparam logic [1:0] ClassCounted = 2'd1;

  typedef struct packed {
    logic        mode;
    logic [4:0]  hop;
    logic [1:0]  reply_class;
    logic [15:0] round_trip;
    logic [31:0] reply_address;
  } req_t;

  typedef struct packed {
    logic [15:0] sent_count;
    logic [15:0] reply_count;
    logic [15:0] best_time;
    logic [15:0] worst_time;
    logic [15:0] last_time;
    logic [15:0] jitter_now;
    logic [15:0] jitter_peak;
    logic [23:0] mean_q8;
    logic [47:0] variance_sum_q16;
    logic [23:0] jitter_mean_q8;
    logic [20:0] jitter_smooth;
    logic [5:0]  path_length;
  } rsp_t;

  typedef struct packed {
    logic [15:0] sent;
    logic [15:0] replies;
    logic [15:0] best;
    logic [15:0] worst;
    logic [15:0] last;
    logic [15:0] jit;
    logic [15:0] jpeak;
    logic [23:0] mean;
    logic [47:0] var_sum;
    logic [23:0] jmean;
    logic [20:0] smooth;
  } entry_t;

endpackage

### rtl/core/phrs_div.sv
// signed by unsigned restoring divider, one quotient bit per cycle
// quotient truncated toward zero; depends on phrs_pkg
module phrs_div import phrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [24:0] dividend_i,
  input  logic [15:0]        divisor_i,
  output logic               done_o,
  output logic signed [24:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [23:0] mag_q;
  logic [16:0] rem_q;
  logic [15:0] dvs_q;
  logic        neg_q;
  logic [24:0] abs_in;
  logic [16:0] rem_sh;
  logic        qbit;

  // magnitude of the dividend and one trial subtraction
  assign abs_in = dividend_i[24] ? (25'd0 - dividend_i) : dividend_i;
  assign rem_sh = {rem_q[15:0], mag_q[23]};
  assign qbit   = (rem_sh >= {1'b0, dvs_q});

  // iteration control and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 5'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= abs_in[23:0];
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[24];
    end else if (busy_q) begin
      rem_q <= qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      mag_q <= {mag_q[22:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (25'sd0 - $signed({1'b0, mag_q})) : $signed({1'b0, mag_q});

endmodule

### rtl/core/per_hop_rtt_statistics.sv
// per-hop round-trip statistics table, top level
// hop entries and hop addresses in two synchronous memories; uses phrs_pkg and phrs_div
//
//   channel   signals                          handshake
//   request   start_i, req_i, busy_o           taken when start_i high and busy_o low
//   result    done_o, result_o                 valid for the single cycle done_o is high
//   config    psel/penable/pwrite/paddr/...    APB write in access phase, pready tied high
//
// a probe with a counted reply goes through entry read, two dividers running side by
// side, multiply, accumulate and write back, then the path-length scan reads one hop
// address per cycle. other probes go from entry read straight to write back and the
// scan; a clear or an out-of-range hop goes straight to the scan.
// reset marks every entry invalid (invalid entries read as zero); a clear request does
// the same. the receiver cannot stall, so done_o is a plain strobe.
module per_hop_rtt_statistics import phrs_pkg::*; #(
  parameter int unsigned HOP_COUNT = HopCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        done_o,
  output rsp_t        result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1;
  localparam int unsigned CntW = $clog2(HOP_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIV, S_MUL, S_ACC, S_WB, S_SCAN
  } state_e;

  state_e state_q;

  // configuration register
  logic [31:0] target_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      target_q <= pwdata;
    end
  end
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : target_q;

  // memories
  entry_t      stats_mem [HOP_COUNT];
  logic [31:0] addr_mem  [HOP_COUNT];
  entry_t      stats_rd_q;
  logic [31:0] addr_rd_q;
  logic        rd_vld_q;
  logic [HOP_COUNT-1:0] vld_q;
  logic [IdxW-1:0] raddr;
  logic            mem_we;

  req_t            req_q;
  logic [IdxW-1:0] idx_q;
  entry_t          wk_q;
  logic [31:0]     addr_new_q;
  logic signed [24:0] x_q;
  logic signed [24:0] dm_q;
  logic signed [49:0] prod_q;
  logic [CntW-1:0] cnt_q;
  logic            found_q;
  logic [CntW-1:0] len_q;
  logic [CntW-1:0] run_q;
  logic [31:0]     prev_q;
  logic            done_q;
  rsp_t            rsp_q;

  assign raddr  = (state_q == S_SCAN) ? IdxW'(cnt_q) : IdxW'(req_i.hop);
  assign mem_we = (state_q == S_WB);

  always_ff @(posedge clk_i) begin
    stats_rd_q <= stats_mem[raddr];
    addr_rd_q  <= addr_mem[raddr];
    if (mem_we) begin
      stats_mem[idx_q] <= wk_q;
      addr_mem[idx_q]  <= addr_new_q;
    end
  end

  // entry update arithmetic, valid in the read-data cycle
  entry_t      cur;
  entry_t      kept;
  logic [31:0] cur_addr;
  logic        first;
  logic [15:0] rtt;
  logic [15:0] jit;
  logic [15:0] best_b, worst_b, peak_b;
  logic [23:0] mean_b;
  logic [20:0] sm_b;
  logic [21:0] sm_sh, sm_sum;
  logic [15:0] sent_n, repl_n;
  logic signed [24:0] x_c, d_c, dj_c;

  always_comb begin
    cur      = rd_vld_q ? stats_rd_q : '0;
    cur_addr = rd_vld_q ? addr_rd_q : 32'd0;
    rtt      = req_q.round_trip;
    first    = (cur.replies == 16'd0);
    sent_n   = (cur.sent == CountMax) ? cur.sent : cur.sent + 16'd1;
    repl_n   = (cur.replies == CountMax) ? cur.replies : cur.replies + 16'd1;
    kept      = cur;
    kept.sent = sent_n;
    if (first) begin
      jit = 16'd0;
    end else begin
      jit = (rtt > cur.last) ? (rtt - cur.last) : (cur.last - rtt);
    end
    best_b  = first ? rtt : cur.best;
    worst_b = first ? rtt : cur.worst;
    peak_b  = first ? 16'd0 : cur.jpeak;
    mean_b  = first ? 24'd0 : cur.mean;
    sm_b    = first ? 21'd0 : cur.smooth;
    x_c     = $signed({1'b0, rtt, 8'h00});
    d_c     = x_c - $signed({1'b0, mean_b});
    dj_c    = $signed({1'b0, jit, 8'h00}) - $signed({1'b0, cur.jmean});
    sm_sh   = ({1'b0, sm_b} + 22'd8) >> 4;
    sm_sum  = {1'b0, sm_b} + 22'(jit) - sm_sh;
  end

  // dividers for the mean and the jitter mean
  logic               div_start;
  logic               dm_done, dj_done;
  logic signed [24:0] qm, qj;
  assign div_start = (state_q == S_READ) && (req_q.reply_class == ClassCounted);

  phrs_div u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (d_c),
    .divisor_i  (repl_n),
    .done_o     (dm_done),
    .quotient_o (qm)
  );

  phrs_div u_div_jit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dj_c),
    .divisor_i  (repl_n),
    .done_o     (dj_done),
    .quotient_o (qj)
  );

  // variance accumulate with saturation
  logic [49:0] var_sum;
  assign var_sum = {2'b00, wk_q.var_sum} + (prod_q[49] ? 50'd0 : prod_q);

  // path-length scan step
  logic [31:0]     scan_a;
  logic [CntW-1:0] scan_i;
  logic            found_n;
  logic [CntW-1:0] len_n, run_n;
  always_comb begin
    scan_a  = rd_vld_q ? addr_rd_q : 32'd0;
    scan_i  = cnt_q - CntW'(1);
    found_n = found_q;
    len_n   = len_q;
    if (!found_q && (scan_a == target_q)) begin
      found_n = 1'b1;
      len_n   = cnt_q;
    end
    if ((cnt_q > CntW'(1)) && (scan_a == prev_q) && (scan_a != 32'd0)) begin
      run_n = run_q;
    end else begin
      run_n = scan_i;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr];
      done_q   <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            req_q <= req_i;
            idx_q <= IdxW'(req_i.hop);
            wk_q  <= '0;
            cnt_q <= '0;
            found_q <= 1'b0;
            if (req_i.mode == ModeClear) begin
              vld_q   <= '0;
              state_q <= S_SCAN;
            end else if (32'(req_i.hop) >= HOP_COUNT) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          if (req_q.reply_class == ClassCounted) begin
            wk_q.sent    <= sent_n;
            wk_q.replies <= repl_n;
            wk_q.best    <= (rtt < best_b) ? rtt : best_b;
            wk_q.worst   <= (rtt > worst_b) ? rtt : worst_b;
            wk_q.last    <= rtt;
            wk_q.jit     <= jit;
            wk_q.jpeak   <= (jit > peak_b) ? jit : peak_b;
            wk_q.mean    <= mean_b;
            wk_q.var_sum <= first ? 48'd0 : cur.var_sum;
            wk_q.jmean   <= cur.jmean;
            wk_q.smooth  <= (sm_sum > {1'b0, SmoothMax}) ? SmoothMax : sm_sum[20:0];
            x_q  <= x_c;
            dm_q <= d_c;
            if (cur_addr == 32'd0 && req_q.reply_address != 32'd0) begin
              addr_new_q <= req_q.reply_address;
            end else begin
              addr_new_q <= cur_addr;
            end
            state_q <= S_DIV;
          end else begin
            addr_new_q <= cur_addr;
            wk_q       <= kept;
            state_q    <= S_WB;
          end
        end
        S_DIV: begin
          if (dm_done && dj_done) begin
            wk_q.mean  <= 24'($signed({1'b0, wk_q.mean}) + qm);
            wk_q.jmean <= 24'($signed({1'b0, wk_q.jmean}) + qj);
            state_q    <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= 50'(dm_q * (x_q - $signed({1'b0, wk_q.mean})));
          state_q <= S_ACC;
        end
        S_ACC: begin
          wk_q.var_sum <= (var_sum > {2'b00, VarMax}) ? VarMax : var_sum[47:0];
          state_q      <= S_WB;
        end
        S_WB: begin
          vld_q[idx_q] <= 1'b1;
          state_q      <= S_SCAN;
        end
        S_SCAN: begin
          if (cnt_q != '0) begin
            found_q <= found_n;
            len_q   <= len_n;
            run_q   <= run_n;
            prev_q  <= scan_a;
          end
          if (cnt_q == CntW'(HOP_COUNT)) begin
            rsp_q.sent_count       <= wk_q.sent;
            rsp_q.reply_count      <= wk_q.replies;
            rsp_q.best_time        <= wk_q.best;
            rsp_q.worst_time       <= wk_q.worst;
            rsp_q.last_time        <= wk_q.last;
            rsp_q.jitter_now       <= wk_q.jit;
            rsp_q.jitter_peak      <= wk_q.jpeak;
            rsp_q.mean_q8          <= wk_q.mean;
            rsp_q.variance_sum_q16 <= wk_q.var_sum;
            rsp_q.jitter_mean_q8   <= wk_q.jmean;
            rsp_q.jitter_smooth    <= wk_q.smooth;
            rsp_q.path_length      <= found_n ? 6'(len_n) : 6'(run_n + CntW'(1));
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
          cnt_q <= cnt_q + CntW'(1);
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

### tb/sv/tb_per_hop_rtt_statistics.sv
// testbench for the per-hop round-trip statistics table
// holds a behavioral model of the hop table and checks every result against it
// depends on phrs_pkg and per_hop_rtt_statistics
`timescale 1ns / 1ps

module tb_per_hop_rtt_statistics;
  import phrs_pkg::*;

  localparam int unsigned Hops       = 32;
  localparam int unsigned DrainWait  = 80;
  localparam longint      CycleLimit = 1500000;
  localparam logic [2:0]  AddrTarget = 3'd0;
  localparam logic        ModeProbe  = 1'b0;
  localparam logic [1:0]  ClassNone  = 2'd0;
  localparam logic [1:0]  ClassError = 2'd2;
  localparam logic [1:0]  ClassSpare = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  req_t        req_i;
  logic        busy_o;
  logic        done_o;
  rsp_t        result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // model copy of the hop table
  logic [15:0] sent_tbl   [Hops];
  logic [15:0] reply_tbl  [Hops];
  logic [15:0] best_tbl   [Hops];
  logic [15:0] worst_tbl  [Hops];
  logic [15:0] last_tbl   [Hops];
  logic [15:0] jit_tbl    [Hops];
  logic [15:0] jpeak_tbl  [Hops];
  longint      mean_tbl   [Hops];
  longint      var_tbl    [Hops];
  longint      jmean_tbl  [Hops];
  longint      smooth_tbl [Hops];
  logic [31:0] addr_tbl   [Hops];
  logic [31:0] target_reg;

  rsp_t   pending_stats[$];
  int     fail_count;
  longint cycle_count = 0;
  int     burst_left;
  logic [31:0] route[Hops];

  per_hop_rtt_statistics #(.HOP_COUNT(Hops)) DUT (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void wipe_table();
    for (int i = 0; i < Hops; i++) begin
      sent_tbl[i] = '0; reply_tbl[i] = '0; best_tbl[i] = '0; worst_tbl[i] = '0;
      last_tbl[i] = '0; jit_tbl[i] = '0; jpeak_tbl[i] = '0; mean_tbl[i] = 0;
      var_tbl[i] = 0; jmean_tbl[i] = 0; smooth_tbl[i] = 0; addr_tbl[i] = '0;
    end
  endfunction

  function automatic logic [5:0] path_guess();
    int len;
    len = Hops;
    for (int i = 0; i < Hops; i++) begin
      if (addr_tbl[i] == target_reg) begin
        len = i + 1;
        break;
      end
    end
    if (len == Hops)
      while (len > 1 && addr_tbl[len-1] == addr_tbl[len-2] && addr_tbl[len-1] != 0)
        len--;
    return len[5:0];
  endfunction

  // welford and jitter update for one counted reply
  function automatic void take_reply(int h, logic [15:0] rtt, logic [31:0] addr);
    logic [15:0] jit;
    longint n, x, d, prod, j, acc;
    jit = (rtt > last_tbl[h]) ? rtt - last_tbl[h] : last_tbl[h] - rtt;
    last_tbl[h] = rtt;
    if (reply_tbl[h] == 0) begin
      best_tbl[h] = rtt; worst_tbl[h] = rtt; mean_tbl[h] = 0; var_tbl[h] = 0;
      jit = '0; jpeak_tbl[h] = '0; smooth_tbl[h] = 0;
    end
    jit_tbl[h] = jit;
    if (rtt < best_tbl[h]) best_tbl[h] = rtt;
    if (rtt > worst_tbl[h]) worst_tbl[h] = rtt;
    if (jit > jpeak_tbl[h]) jpeak_tbl[h] = jit;
    if (reply_tbl[h] != CountMax) reply_tbl[h]++;
    n = reply_tbl[h];
    x = longint'(rtt) * 256;
    d = x - mean_tbl[h];
    mean_tbl[h] += d / n;
    prod = d * (x - mean_tbl[h]);
    if (prod < 0) prod = 0;
    var_tbl[h] += prod;
    if (var_tbl[h] > longint'(VarMax)) var_tbl[h] = longint'(VarMax);
    j = longint'(jit) * 256;
    jmean_tbl[h] += (j - jmean_tbl[h]) / n;
    acc = smooth_tbl[h];
    acc += longint'(jit) - (acc + 8) / 16;
    if (acc < 0) acc = 0;
    if (acc > longint'(SmoothMax)) acc = longint'(SmoothMax);
    smooth_tbl[h] = acc;
    if (addr_tbl[h] == 0 && addr != 0) addr_tbl[h] = addr;
  endfunction

  function automatic rsp_t hop_stats_after(req_t r);
    rsp_t s;
    int h;
    h = r.hop;
    if (r.mode == ModeClear) wipe_table();
    else begin
      if (sent_tbl[h] != CountMax) sent_tbl[h]++;
      if (r.reply_class == ClassCounted) take_reply(h, r.round_trip, r.reply_address);
    end
    s.sent_count       = sent_tbl[h];
    s.reply_count      = reply_tbl[h];
    s.best_time        = best_tbl[h];
    s.worst_time       = worst_tbl[h];
    s.last_time        = last_tbl[h];
    s.jitter_now       = jit_tbl[h];
    s.jitter_peak      = jpeak_tbl[h];
    s.mean_q8          = mean_tbl[h][23:0];
    s.variance_sum_q16 = var_tbl[h][47:0];
    s.jitter_mean_q8   = jmean_tbl[h][23:0];
    s.jitter_smooth    = smooth_tbl[h][20:0];
    s.path_length      = path_guess();
    return s;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && done_o) begin
      if (pending_stats.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = pending_stats.pop_front();
        check_field("sent_count", e.sent_count, result_o.sent_count);
        check_field("reply_count", e.reply_count, result_o.reply_count);
        check_field("best_time", e.best_time, result_o.best_time);
        check_field("worst_time", e.worst_time, result_o.worst_time);
        check_field("last_time", e.last_time, result_o.last_time);
        check_field("jitter_now", e.jitter_now, result_o.jitter_now);
        check_field("jitter_peak", e.jitter_peak, result_o.jitter_peak);
        check_field("mean_q8", e.mean_q8, result_o.mean_q8);
        check_field("variance_sum_q16", e.variance_sum_q16, result_o.variance_sum_q16);
        check_field("jitter_mean_q8", e.jitter_mean_q8, result_o.jitter_mean_q8);
        check_field("jitter_smooth", e.jitter_smooth, result_o.jitter_smooth);
        check_field("path_length", e.path_length, result_o.path_length);
      end
    end
  end

  // issue one request, bursts with random gaps between them
  task automatic send_request(req_t r);
    int gap;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    pending_stats.push_back(hop_stats_after(r));
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
    end else burst_left--;
  endtask

  task automatic send_probe(logic [4:0] h, logic [1:0] cls, logic [15:0] rtt,
                            logic [31:0] addr);
    req_t r;
    r.mode = ModeProbe; r.hop = h; r.reply_class = cls;
    r.round_trip = rtt; r.reply_address = addr;
    send_request(r);
  endtask

  task automatic send_clear();
    req_t r;
    r.mode = ModeClear; r.hop = 5'($urandom_range(0, 31)); r.reply_class = 2'($urandom);
    r.round_trip = 16'($urandom); r.reply_address = $urandom;
    send_request(r);
  endtask

  // wait for every outstanding request to finish and the block to settle
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_target(logic [31:0] value);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= AddrTarget; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    target_reg = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // field extremes, every reply class, first reply, clear
  task automatic test_directed();
    send_probe(5'd0, ClassNone, 16'd0, 32'd0);
    send_probe(5'd0, ClassCounted, 16'd100, 32'h0A000001);
    send_probe(5'd0, ClassCounted, 16'd0, 32'h0A000002);
    send_probe(5'd0, ClassCounted, 16'hFFFF, 32'd0);
    send_probe(5'd0, ClassCounted, 16'hFFFF, 32'hFFFFFFFF);
    send_probe(5'd31, ClassCounted, 16'hFFFF, 32'hFFFFFFFF);
    send_probe(5'd31, ClassCounted, 16'd0, 32'h0);
    send_probe(5'd31, ClassError, 16'd5, 32'h12345678);
    send_probe(5'd31, ClassSpare, 16'hAAAA, 32'h55555555);
    send_probe(5'd7, ClassCounted, 16'h5555, 32'd0);
    send_probe(5'd7, ClassCounted, 16'hAAAA, 32'hAAAAAAAA);
    send_probe(5'd7, ClassNone, 16'h1234, 32'h55555555);
    send_probe(5'd30, ClassCounted, 16'd3, 32'hFFFFFFFF);
    send_clear();
    send_probe(5'd0, ClassCounted, 16'd40, 32'h0A000001);
    send_probe(5'd0, ClassCounted, 16'd41, 32'h0A000001);
    drain();
  endtask

  // path length: target found, not found, repeated tail addresses
  task automatic test_path_length();
    write_target(32'h0A000001);
    send_probe(5'd0, ClassNone, 16'd1, 32'd0);
    write_target(32'hFFFFFFFF);
    send_probe(5'd29, ClassCounted, 16'd9, 32'hC0A80001);
    send_probe(5'd30, ClassCounted, 16'd9, 32'hC0A80001);
    send_probe(5'd31, ClassCounted, 16'd9, 32'hC0A80001);
    send_clear();
    write_target(32'd0);
    send_probe(5'd1, ClassCounted, 16'd2, 32'h1);
    drain();
  endtask

  // random routes per phase with mostly well-formed probes
  task automatic test_random_routes(int items);
    int   done_items, pick, h;
    logic [15:0] base_rtt;
    done_items = 0;
    while (done_items < items) begin
      for (int i = 0; i < Hops; i++) route[i] = $urandom;
      pick = $urandom_range(0, 3);
      if (pick == 0) for (int i = $urandom_range(1, 30); i < Hops; i++) route[i] = route[Hops-1];
      case ($urandom_range(0, 4))
        0: write_target(32'd0);
        1: write_target(32'hFFFFFFFF);
        2: write_target($urandom);
        default: write_target(route[$urandom_range(0, Hops - 1)]);
      endcase
      for (int k = 0; k < 150 && done_items < items; k++) begin
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, Hops - 1) : $urandom_range(0, 11);
        base_rtt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(h * 5 + $urandom_range(0, 30));
        case ($urandom_range(0, 19))
          0: send_clear();
          1, 2: send_probe(5'(h), ClassNone, 16'($urandom), 32'($urandom));
          3: send_probe(5'(h), 2'($urandom_range(2, 3)), base_rtt, route[h]);
          4: send_probe(5'(h), ClassCounted, base_rtt, ($urandom_range(0, 1)) ? 32'd0 : $urandom);
          default: send_probe(5'(h), ClassCounted, base_rtt, route[h]);
        endcase
        done_items++;
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0; start_i = 1'b0; req_i = '0; psel = 1'b0; penable = 1'b0;
    pwrite = 1'b0; paddr = '0; pwdata = '0;
    fail_count = 0; burst_left = 0; target_reg = '0;
    wipe_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_path_length();
    test_random_routes(1750);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
